// File: rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types and constants of the LFU cache table.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    localparam int          CAP_BITS     = 5;
    localparam logic [4:0]  CAP_RESET    = 5'd16;
    localparam logic        REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] read_data;
        logic               evicted;
        logic signed [31:0] evicted_key;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SWEEP,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_HIT,
        MODE_EVICT,
        MODE_FREE
    } t_mode;

    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
        logic sweep;
    } t_ctl;

    typedef struct packed {
        logic last;
        logic need_sweep;
    } t_sts;

endpackage

// File: rtl/lfu_ram.sv
// ----------------------------------------------------------------------------
// lfu_ram
// Generic RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer of one request: scan, decide, rank sweep when needed, result.
// ----------------------------------------------------------------------------
module lfu_ctrl import lfu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_ctl o_ctl,
    output logic o_busy,
    output logic o_done
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_start) n_state = S_SCAN;
            S_SCAN:   if (i_sts.last) n_state = S_DECIDE;
            S_DECIDE: n_state = i_sts.need_sweep ? S_SWEEP : S_DONE;
            S_SWEEP:  if (i_sts.last) n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl        = '0;
        o_ctl.load   = (r_state == S_IDLE) && i_start;
        o_ctl.scan   = (r_state == S_SCAN);
        o_ctl.decide = (r_state == S_DECIDE);
        o_ctl.sweep  = (r_state == S_SWEEP);
        o_busy       = (r_state != S_IDLE);
        o_done       = (r_state == S_DONE);
    end

    // A result is shown for exactly one cycle and the block then returns to idle.
    a_done_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_state == S_IDLE))
        else $error("result strobe held longer than one cycle");

endmodule

// File: rtl/lfu_dp.sv
// ----------------------------------------------------------------------------
// lfu_dp
// Entry storage, sequential scan for hit, victim and free entry, rank sweep.
// ----------------------------------------------------------------------------
module lfu_dp import lfu_pkg::*; #(
    parameter int MAX_ENTRIES = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctl                i_ctl,
    input  t_req                i_req,
    input  logic [CAP_BITS-1:0] i_capacity,
    output t_sts                o_sts,
    output t_res                o_res
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OW = $clog2(MAX_ENTRIES + 1);
    localparam int CW = (OW > CAP_BITS) ? OW : CAP_BITS;
    localparam int WW = 64 + COUNT_BITS + AW;
    localparam logic [AW-1:0] LAST = AW'(MAX_ENTRIES - 1);

    t_req                   r_req;
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [OW-1:0]          r_occ;
    logic [AW-1:0]          r_addr;
    logic [AW-1:0]          r_paddr;
    logic                   r_all;
    logic                   r_pend;

    logic                   r_hit;
    logic [AW-1:0]          r_hslot;
    logic [31:0]            r_rd;
    logic [AW-1:0]          r_hrank;
    logic                   r_vfound;
    logic [AW-1:0]          r_vslot;
    logic [COUNT_BITS-1:0]  r_vcnt;
    logic [AW-1:0]          r_vrank;
    logic [31:0]            r_vkey;
    logic                   r_ffound;
    logic [AW-1:0]          r_fslot;

    t_mode                  r_mode;
    logic [AW-1:0]          r_slot;
    t_res                   r_res;

    logic                   issue;
    logic [WW-1:0]          ram_rdata;
    logic [WW-1:0]          ram_wdata;
    logic                   ram_we;
    logic [31:0]            rd_key;
    logic [31:0]            rd_data;
    logic [COUNT_BITS-1:0]  rd_cnt;
    logic [AW-1:0]          rd_rank;
    logic                   rd_valid;

    logic                   is_put;
    logic [CW-1:0]          cap_c;
    logic                   cap_zero;
    t_mode                  n_mode;
    logic [AW-1:0]          n_slot;

    logic [31:0]            w_key;
    logic [31:0]            w_data;
    logic [COUNT_BITS-1:0]  w_cnt;
    logic [AW-1:0]          w_rank;

    assign rd_key   = ram_rdata[WW-1 -: 32];
    assign rd_data  = ram_rdata[WW-33 -: 32];
    assign rd_cnt   = ram_rdata[AW+COUNT_BITS-1 : AW];
    assign rd_rank  = ram_rdata[AW-1:0];
    assign rd_valid = r_valid[r_paddr];

    assign issue = (i_ctl.scan || i_ctl.sweep) && !r_all;

    lfu_ram #(.WIDTH(WW), .DEPTH(MAX_ENTRIES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_paddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // Address sequencer shared by the scan and the sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_all  <= 1'b1;
            r_addr <= '0;
        end else begin
            r_pend <= issue;
            if (i_ctl.load || i_ctl.decide) begin
                r_addr <= '0;
                r_all  <= 1'b0;
            end else if (issue) begin
                if (r_addr == LAST) begin
                    r_all <= 1'b1;
                end else begin
                    r_addr <= r_addr + 1'b1;
                end
            end
        end
        r_paddr <= r_addr;
    end

    assign o_sts.last = r_pend && (r_paddr == LAST);

    // Decision from the scan results.
    always_comb begin
        is_put   = (r_req.opcode == OP_PUT);
        cap_c    = (CW'(i_capacity) > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(i_capacity);
        cap_zero = (cap_c == '0);
        n_mode   = MODE_NONE;
        n_slot   = r_fslot;
        priority if (is_put && cap_zero) begin
            n_mode = MODE_NONE;
        end else if (r_hit) begin
            n_mode = MODE_HIT;
            n_slot = r_hslot;
        end else if (is_put) begin
            if (CW'(r_occ) >= cap_c) begin
                n_mode = MODE_EVICT;
                n_slot = r_vslot;
            end else begin
                n_mode = MODE_FREE;
                n_slot = r_fslot;
            end
        end else begin
            n_mode = MODE_NONE;
        end
    end

    assign o_sts.need_sweep = (n_mode != MODE_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            r_mode  <= MODE_NONE;
        end else begin
            if (i_ctl.decide) begin
                r_mode <= n_mode;
                if (n_mode == MODE_FREE) begin
                    r_valid[n_slot] <= 1'b1;
                    r_occ           <= r_occ + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_req    <= i_req;
            r_hit    <= 1'b0;
            r_vfound <= 1'b0;
            r_ffound <= 1'b0;
        end else if (i_ctl.scan && r_pend) begin
            if (rd_valid) begin
                if (rd_key == r_req.key) begin
                    r_hit   <= 1'b1;
                    r_hslot <= r_paddr;
                    r_rd    <= rd_data;
                    r_hrank <= rd_rank;
                end
                if (!r_vfound || (rd_cnt < r_vcnt) ||
                    ((rd_cnt == r_vcnt) && (rd_rank > r_vrank))) begin
                    r_vfound <= 1'b1;
                    r_vslot  <= r_paddr;
                    r_vcnt   <= rd_cnt;
                    r_vrank  <= rd_rank;
                    r_vkey   <= rd_key;
                end
            end else if (!r_ffound) begin
                r_ffound <= 1'b1;
                r_fslot  <= r_paddr;
            end
        end
        if (i_ctl.decide) begin
            r_slot              <= n_slot;
            r_res.hit           <= r_hit && !(is_put && cap_zero);
            r_res.read_data     <= (r_hit && !(is_put && cap_zero)) ? r_rd : 32'd0;
            r_res.evicted       <= (n_mode == MODE_EVICT);
            r_res.evicted_key   <= (n_mode == MODE_EVICT) ? r_vkey : 32'd0;
        end
    end

    // Rank sweep: the chosen entry gets its new contents and rank zero; the others that were more recent than it age.
    always_comb begin
        w_key  = rd_key;
        w_data = rd_data;
        w_cnt  = rd_cnt;
        w_rank = rd_rank;
        if (r_paddr == r_slot) begin
            w_rank = '0;
            if (r_mode == MODE_HIT) begin
                if (is_put) w_data = r_req.value;
                if (rd_cnt != '1) w_cnt = rd_cnt + 1'b1;
            end else begin
                w_key  = r_req.key;
                w_data = r_req.value;
                w_cnt  = COUNT_BITS'(1);
            end
        end else begin
            unique case (r_mode)
                MODE_HIT:   if (rd_rank < r_hrank) w_rank = rd_rank + 1'b1;
                MODE_EVICT: w_rank = rd_rank + 1'b1 - AW'(rd_rank > r_vrank);
                MODE_FREE:  w_rank = rd_rank + 1'b1;
                MODE_NONE:  w_rank = rd_rank;
                default:    w_rank = rd_rank;
            endcase
        end
        ram_wdata = {w_key, w_data, w_cnt, w_rank};
        ram_we    = i_ctl.sweep && r_pend && (rd_valid || (r_paddr == r_slot));
    end

    assign o_res = r_res;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_occ) <= MAX_ENTRIES)
        else $error("occupancy above table size");

    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'($countones(r_valid)) == 32'(r_occ))
        else $error("occupancy out of step with valid bits");

    a_hit_not_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.decide |=> !(r_res.hit && r_res.evicted))
        else $error("hit and eviction reported together");

endmodule

// File: rtl/lfu_cache_table.sv
// ----------------------------------------------------------------------------
// lfu_cache_table
// Key-value cache with least-frequently-used replacement and LRU tie break.
// ----------------------------------------------------------------------------
// One request is taken when start is high and busy is low. A get or a put
// that hits, or a put that inserts, makes two passes over the entry memory:
// the first looks up the key and finds the victim and the first free entry,
// one read per cycle, and the second rewrites every entry's recency rank. A
// get that misses, and a put while the capacity is zero, make only the first
// pass. Both passes go through the single read port of the entry memory. The
// result is shown on o_res for exactly one cycle with o_valid high, and the
// receiver cannot hold it off; busy drops in the cycle after it. The user
// must write the capacity register through the APB port only while the block
// is idle; the block itself does not enforce it. Values above the table size
// act as the table size, and zero makes every put a no-op.
module lfu_cache_table import lfu_pkg::*; #(
    parameter int MAX_ENTRIES = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    output logic        o_valid,
    output t_res        o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CAP_BITS-1:0] r_capacity;
    t_ctl                ctl;
    t_sts                sts;

    // The capacity register answers at byte addresses zero to three (paddr[2] low); addresses four and up are ignored.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_CAPACITY)) begin
            r_capacity <= pwdata[CAP_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32-CAP_BITS){1'b0}}, r_capacity} : 32'd0;

    lfu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy),
        .o_done  (o_valid)
    );

    lfu_dp #(.MAX_ENTRIES(MAX_ENTRIES), .COUNT_BITS(COUNT_BITS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_req      (i_req),
        .i_capacity (r_capacity),
        .o_sts      (sts),
        .o_res      (o_res)
    );

endmodule
